// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Clocked assertion with reset disable, and an implication form built on it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication helper on top of FPA_ASSERT.
`define FPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`FPA_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== hdl/fpa_pkg.sv =====
// Package for the Q24.8 fixed-point ALU: widths, opcodes, status codes,
// pipeline payload types and small helpers. No dependencies.
package fpa_pkg;

	localparam int FRACTION_BITS   = 8;
	localparam int DATA_W          = 32;
	localparam int PROD_W          = 2 * DATA_W;
	localparam int NUM_W           = DATA_W + FRACTION_BITS;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = DATA_W / STEPS_PER_STAGE;
	localparam int PIPE_DEPTH      = DIV_STAGES + 2;
	localparam int OUT_W           = 40;

	localparam logic [3:0] OP_ADD     = 4'd0;
	localparam logic [3:0] OP_SUB     = 4'd1;
	localparam logic [3:0] OP_MUL     = 4'd2;
	localparam logic [3:0] OP_DIV     = 4'd3;
	localparam logic [3:0] OP_LT      = 4'd4;
	localparam logic [3:0] OP_LE      = 4'd5;
	localparam logic [3:0] OP_GT      = 4'd6;
	localparam logic [3:0] OP_GE      = 4'd7;
	localparam logic [3:0] OP_EQ      = 4'd8;
	localparam logic [3:0] OP_NE      = 4'd9;
	localparam logic [3:0] OP_MIN     = 4'd10;
	localparam logic [3:0] OP_MAX     = 4'd11;
	localparam logic [3:0] OP_INC     = 4'd12;
	localparam logic [3:0] OP_DEC     = 4'd13;
	localparam logic [3:0] OP_TOINT   = 4'd14;
	localparam logic [3:0] OP_FROMINT = 4'd15;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	localparam logic signed [DATA_W-1:0] RAW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] RAW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [DATA_W:0]   rem;
		logic [DATA_W-1:0] num;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] den;
	} div_t;

	typedef struct packed {
		logic [3:0]               op;
		logic signed [DATA_W-1:0] res;
		logic                     cmp;
		logic [1:0]               status;
		logic signed [PROD_W-1:0] prod;
		logic                     a_neg;
		logic                     b_zero;
		logic                     q_neg;
		logic                     div_ovf;
		div_t                     dv;
	} pipe_t;

	function automatic logic signed [DATA_W-1:0] sat(input logic neg);
		return neg ? RAW_MIN : RAW_MAX;
	endfunction

endpackage

// ===== hdl/fpa_front.sv =====
// First stage: simple operations, 32x32 multiply and divider set-up.
// Depends on fpa_pkg.
module fpa_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [3:0]                  op,
	input  logic signed [31:0]          a,
	input  logic signed [31:0]          b,
	output logic                        valid_s1,
	output fpa_pkg::pipe_t              pipe_s1
);
	import fpa_pkg::*;

	pipe_t                    nxt;
	logic signed [DATA_W:0]   sum, dif, incv, decv;
	logic [DATA_W-1:0]        mag_a, mag_b, tq;
	logic [NUM_W-1:0]         n;
	logic signed [PROD_W-1:0] wide;
	logic [DATA_W:0]          hi;

	function automatic logic [DATA_W+2:0] clamp33(input logic signed [DATA_W:0] v);
		// {status, cmp, value}
		if (v[DATA_W] != v[DATA_W-1])
			return {ST_OVF, 1'b0, sat(v[DATA_W])};
		return {ST_OK, 1'b0, v[DATA_W-1:0]};
	endfunction

	always_comb begin
		sum   = {a[DATA_W-1], a} + {b[DATA_W-1], b};
		dif   = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		incv  = {a[DATA_W-1], a} + {{DATA_W{1'b0}}, 1'b1};
		decv  = {a[DATA_W-1], a} - {{DATA_W{1'b0}}, 1'b1};
		mag_a = a[DATA_W-1] ? (~a + 1'b1) : a;
		mag_b = b[DATA_W-1] ? (~b + 1'b1) : b;
		n     = {mag_a, {FRACTION_BITS{1'b0}}};
		tq    = mag_a >> FRACTION_BITS;
		wide  = {{DATA_W{a[DATA_W-1]}}, a} <<< FRACTION_BITS;
		hi    = wide[PROD_W-1:DATA_W-1];

		nxt          = '0;
		nxt.op       = op;
		nxt.prod     = a * b;
		nxt.a_neg    = a[DATA_W-1];
		nxt.b_zero   = (b == '0);
		nxt.q_neg    = a[DATA_W-1] ^ b[DATA_W-1];
		nxt.div_ovf  = ({{(DATA_W-FRACTION_BITS){1'b0}}, n[NUM_W-1:DATA_W]} >= mag_b);
		nxt.dv.rem   = {{(DATA_W+1-FRACTION_BITS){1'b0}}, n[NUM_W-1:DATA_W]};
		nxt.dv.num   = n[DATA_W-1:0];
		nxt.dv.quo   = '0;
		nxt.dv.den   = mag_b;

		case (op)
			OP_ADD: {nxt.status, nxt.cmp, nxt.res} = clamp33(sum);
			OP_SUB: {nxt.status, nxt.cmp, nxt.res} = clamp33(dif);
			OP_INC: {nxt.status, nxt.cmp, nxt.res} = clamp33(incv);
			OP_DEC: {nxt.status, nxt.cmp, nxt.res} = clamp33(decv);
			OP_LT:  nxt.cmp = (a < b);
			OP_LE:  nxt.cmp = (a <= b);
			OP_GT:  nxt.cmp = (a > b);
			OP_GE:  nxt.cmp = (a >= b);
			OP_EQ:  nxt.cmp = (a == b);
			OP_NE:  nxt.cmp = (a != b);
			OP_MIN: nxt.res = (a <= b) ? a : b;
			OP_MAX: nxt.res = (a >= b) ? a : b;
			OP_TOINT: nxt.res = a[DATA_W-1] ? (~tq + 1'b1) : tq;
			OP_FROMINT: begin
				if ((&hi) || !(|hi))
					nxt.res = wide[DATA_W-1:0];
				else begin
					nxt.res    = sat(a[DATA_W-1]);
					nxt.status = ST_OVF;
				end
			end
			default: ;  // mul and div finish in the last stage
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			pipe_s1 <= nxt;
	end

endmodule

// ===== hdl/fpa_div_stage.sv =====
// One divider stage: STEPS_PER_STAGE restoring quotient steps, rest of the
// payload passed through. Depends on fpa_pkg.
module fpa_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  fpa_pkg::pipe_t pipe_in,
	output logic           valid_s,
	output fpa_pkg::pipe_t pipe_s
);
	import fpa_pkg::*;

	pipe_t           nxt;
	logic [DATA_W:0] r;

	always_comb begin
		nxt = pipe_in;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			r = {nxt.dv.rem[DATA_W-1:0], nxt.dv.num[DATA_W-1]};
			nxt.dv.num = {nxt.dv.num[DATA_W-2:0], 1'b0};
			if (r >= {1'b0, nxt.dv.den}) begin
				nxt.dv.rem = r - {1'b0, nxt.dv.den};
				nxt.dv.quo = {nxt.dv.quo[DATA_W-2:0], 1'b1};
			end else begin
				nxt.dv.rem = r;
				nxt.dv.quo = {nxt.dv.quo[DATA_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s <= 1'b0;
		else if (en)
			valid_s <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			pipe_s <= nxt;
	end

endmodule

// ===== hdl/fpa_back.sv =====
// Last stage: rounding, sign and saturation for mul and div, result
// selection and the output register. Depends on fpa_pkg.
module fpa_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  fpa_pkg::pipe_t       pipe_in,
	output logic                 valid_s,
	output logic signed [31:0]   res_s,
	output logic                 cmp_s,
	output logic [1:0]           status_s
);
	import fpa_pkg::*;

	logic [DATA_W:0]          q;
	logic [PROD_W-1:0]        pm, m;
	logic signed [DATA_W-1:0] res;
	logic [1:0]               st;
	logic                     pneg;

	always_comb begin
		q = {1'b0, pipe_in.dv.quo} +
			{{DATA_W{1'b0}}, ({pipe_in.dv.rem, 1'b0} >= {2'b00, pipe_in.dv.den})};
		pneg = pipe_in.prod[PROD_W-1];
		pm = pneg ? (~pipe_in.prod + 1'b1) : pipe_in.prod;
		m  = (pm + (PROD_W'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;

		res = pipe_in.res;
		st  = pipe_in.status;
		case (pipe_in.op)
			OP_MUL: begin
				st = ST_OK;
				if (!pneg && (m > PROD_W'(RAW_MAX))) begin
					res = RAW_MAX;
					st  = ST_OVF;
				end else if (pneg && (m > (PROD_W'(1) << (DATA_W - 1)))) begin
					res = RAW_MIN;
					st  = ST_OVF;
				end else
					res = pneg ? (~m[DATA_W-1:0] + 1'b1) : m[DATA_W-1:0];
			end
			OP_DIV: begin
				st = ST_OK;
				if (pipe_in.b_zero) begin
					res = sat(pipe_in.a_neg);
					st  = ST_DIVZ;
				end else if (pipe_in.div_ovf) begin
					res = sat(pipe_in.q_neg);
					st  = ST_OVF;
				end else if (!pipe_in.q_neg && (q[DATA_W] || q[DATA_W-1])) begin
					res = RAW_MAX;
					st  = ST_OVF;
				end else if (pipe_in.q_neg &&
						(q > {2'b01, {(DATA_W-1){1'b0}}})) begin
					res = RAW_MIN;
					st  = ST_OVF;
				end else
					res = pipe_in.q_neg ? (~q[DATA_W-1:0] + 1'b1) : q[DATA_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s <= 1'b0;
		else if (en)
			valid_s <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s    <= res;
			cmp_s    <= pipe_in.cmp;
			status_s <= st;
		end
	end

endmodule

// ===== hdl/fixed_point_alu_q24_8_unit.sv =====
// Q24.8 fixed-point ALU, streaming in and out.
// Stages: front stage, 8 divider stages of 4 quotient bits each, and the
// rounding/output stage.
// Throughput: one request per cycle; each stage stalls only while full
// and the stage after it cannot move. Reset clears all valid bits.
module fixed_point_alu_q24_8_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
	input  logic [3:0]  s_tuser,   // operation[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // result_value[31:0], compare_true[32], status[34:33], zero
);
	import fpa_pkg::*;

	logic [PIPE_DEPTH-1:0] v;
	logic [PIPE_DEPTH-1:0] en;
	pipe_t                 pipe [DIV_STAGES+1];
	logic signed [31:0]    res;
	logic                  cmp;
	logic [1:0]            status;

	// stage moves when empty or when the next one moves
	always_comb begin
		en[PIPE_DEPTH-1] = !v[PIPE_DEPTH-1] || m_tready;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--)
			en[k] = !v[k] || en[k+1];
	end

	assign s_tready = en[0];

	fpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[0]),
		.in_valid (s_tvalid),
		.op       (s_tuser),
		.a        (s_tdata[31:0]),
		.b        (s_tdata[63:32]),
		.valid_s1 (v[0]),
		.pipe_s1  (pipe[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		fpa_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en[g+1]),
			.in_valid (v[g]),
			.pipe_in  (pipe[g]),
			.valid_s  (v[g+1]),
			.pipe_s   (pipe[g+1])
		);
	end

	fpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[PIPE_DEPTH-1]),
		.in_valid (v[PIPE_DEPTH-2]),
		.pipe_in  (pipe[DIV_STAGES]),
		.valid_s  (v[PIPE_DEPTH-1]),
		.res_s    (res),
		.cmp_s    (cmp),
		.status_s (status)
	);

	assign m_tvalid = v[PIPE_DEPTH-1];
	assign m_tdata  = {{(OUT_W-DATA_W-3){1'b0}}, status, cmp, res};

endmodule

// ===== hdl/fpa_checker.sv =====
// Port-level checks on the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	import fpa_pkg::*;

	`FPA_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`FPA_ASSERT_IMPL(a_status, clk, arst_n, m_tvalid, m_tdata[34:33] != 2'd3, "undefined status code")
	`FPA_ASSERT_IMPL(a_cmp, clk, arst_n, m_tvalid && m_tdata[32], (m_tdata[31:0] == '0) && (m_tdata[34:33] == ST_OK), "comparison result carries value or status")
	`FPA_ASSERT_IMPL(a_divz, clk, arst_n, m_tvalid && (m_tdata[34:33] == ST_DIVZ), (m_tdata[31:0] == RAW_MAX) || (m_tdata[31:0] == RAW_MIN), "division by zero not saturated")

endmodule

bind fixed_point_alu_q24_8_unit fpa_checker u_fpa_checker (.*);
